>>> rtl/path_oram_access_defines.svh
// Assertion shorthands used by path_oram_access.sv.
`ifndef PATH_ORAM_ACCESS_DEFINES_SVH
`define PATH_ORAM_ACCESS_DEFINES_SVH

// Same-cycle implication.
`define POA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define POA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/poram_pkg.sv
package poram_pkg;
   localparam int TREE_DEPTH_DEF   = 4;
   localparam int BUCKET_SLOTS_DEF = 2;
   localparam int STASH_DEPTH_DEF  = 32;
   localparam int ADDR_BITS_DEF    = 32;

   localparam int LABEL_W    = 5;
   localparam int IN_ADDR_W  = 32;
   localparam int CNT_OUT_W  = 6;
   localparam int STATUS_W   = 2;
   localparam int LFSR_W     = 32;
   localparam int LFSR_CHUNK = 8;
   localparam int LFSR_ROUNDS = LFSR_W / LFSR_CHUNK;
   localparam logic [LFSR_W-1:0] LFSR_MASK = 32'hD000_0001;

   localparam logic OP_PLACE  = 1'b0;
   localparam logic OP_ACCESS = 1'b1;

   localparam logic KIND_TRACE = 1'b0;
   localparam logic KIND_DONE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_SLOT  = 2'd2;

   localparam logic CSR_DUMMY_EN = 1'b0;
   localparam logic CSR_SEED     = 1'b1;

   typedef struct packed {
      logic              load;
      logic              start;
      logic [LFSR_W-1:0] seed;
   } lfsr_ctrl_type;

   // Eight Galois shifts, right-shifting form.
   function automatic logic [LFSR_W-1:0] lfsr_chunk(input logic [LFSR_W-1:0] v);
      logic [LFSR_W-1:0] r;
      r = v;
      for (int i = 0; i < LFSR_CHUNK; i++) begin
         r = r[0] ? ((r >> 1) ^ LFSR_MASK) : (r >> 1);
      end
      return r;
   endfunction
endpackage

>>> rtl/path_oram_access.sv
// Path ORAM bucket tree with a bounded stash.
// req channel: tuser = op (0 place, 1 access); tdata = leaf, address, new_label.
// rsp channel: tuser = kind (0 read trace, 1 completion); tlast on the completion;
//   tdata = read_address, stash_count, status.
// csr port: index 0 dummy_fill_enable, index 1 random_seed (reloads the generator).
// A place walks the path up to the first free slot and ends with one completion.
// An access reads the S path slots, then sweeps the F stash entries once per
// tree level during write-back, then fills the empty path slots with dummies
// when dummy_fill_enable is set, and then sends the results.
// Traces are buffered and sent after write-back so each carries the final fill.
// req_tready is high only while no request is in progress; a stalled receiver
// holds the sequencer at the next result. Reset empties the tree (valid bits) and
// the stash (fill count) at once, no clearing pass, and reloads the generator with 1.
`include "path_oram_access_defines.svh"

module path_oram_access #(
   parameter int TREE_DEPTH   = poram_pkg::TREE_DEPTH_DEF,
   parameter int BUCKET_SLOTS = poram_pkg::BUCKET_SLOTS_DEF,
   parameter int STASH_DEPTH  = poram_pkg::STASH_DEPTH_DEF,
   parameter int ADDR_BITS    = poram_pkg::ADDR_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // leaf[4:0], address[36:5], new_label[41:37], zero pad
   input  logic        req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // read_address[31:0], stash_count[37:32], status[39:38]
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);
   import poram_pkg::*;

   localparam int LEAVES   = 1 << TREE_DEPTH;
   localparam int NODES    = 2 * LEAVES - 1;
   localparam int SLOTS    = NODES * BUCKET_SLOTS;
   localparam int NODE_W   = TREE_DEPTH + 1;
   localparam int SB_W     = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
   localparam int SH_W     = $clog2(TREE_DEPTH + 1);
   localparam int SLOT_IW  = $clog2(SLOTS);
   localparam int FILL_W   = $clog2(STASH_DEPTH + 1);
   localparam int STASH_IW = $clog2(STASH_DEPTH);
   localparam int TRACES   = (TREE_DEPTH + 1) * BUCKET_SLOTS;
   localparam int TCNT_W   = $clog2(TRACES + 1);
   localparam int TIDX_W   = $clog2(TRACES);
   localparam int ENTRY_W  = LABEL_W + ADDR_BITS;
   localparam int TRACE_W  = 1 + IN_ADDR_W;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_P_RD   = 4'd1;
   localparam logic [3:0] S_P_EV   = 4'd2;
   localparam logic [3:0] S_A_RD   = 4'd3;
   localparam logic [3:0] S_A_EV   = 4'd4;
   localparam logic [3:0] S_W_RD   = 4'd5;
   localparam logic [3:0] S_W_EV   = 4'd6;
   localparam logic [3:0] S_D_RD   = 4'd7;
   localparam logic [3:0] S_D_EV   = 4'd8;
   localparam logic [3:0] S_D_GEN  = 4'd9;
   localparam logic [3:0] S_E_RD   = 4'd10;
   localparam logic [3:0] S_E_EV   = 4'd11;
   localparam logic [3:0] S_E_DONE = 4'd12;

   logic [3:0]           state_ff, state_in;
   logic                 op_ff, op_in;
   logic [NODE_W-1:0]    leaf_ff, leaf_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [LABEL_W-1:0]   nl_ff, nl_in;
   logic [NODE_W-1:0]    node_ff, node_in;
   logic [SB_W-1:0]      slot_ff, slot_in;
   logic [SH_W-1:0]      sh_ff, sh_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [FILL_W-1:0]    j_ff, j_in;
   logic [FILL_W-1:0]    w_ff, w_in;
   logic                 full_ff, full_in;
   logic [TCNT_W-1:0]    tcnt_ff, tcnt_in;
   logic [TCNT_W-1:0]    eidx_ff, eidx_in;
   logic                 dfe_ff, dfe_in;
   logic [SLOT_IW-1:0]   rd_idx_ff, rd_idx_in;
   logic [SLOTS-1:0]     vld_ff, vld_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_kind_ff, rsp_kind_in;
   logic [IN_ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [CNT_OUT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic [STATUS_W-1:0]  rsp_st_ff, rsp_st_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 slot_we, slot_re;
   logic [SLOT_IW-1:0]   slot_waddr;
   logic [ENTRY_W-1:0]   slot_wdata, slot_rdata;
   logic                 stash_we, stash_re;
   logic [STASH_IW-1:0]  stash_waddr, stash_raddr;
   logic [ENTRY_W-1:0]   stash_wdata, stash_rdata;
   logic                 trace_we, trace_re;
   logic [TIDX_W-1:0]    trace_waddr, trace_raddr;
   logic [TRACE_W-1:0]   trace_wdata, trace_rdata;

   lfsr_ctrl_type        lfsr_ctrl;
   logic [LFSR_W-1:0]    lfsr_value;
   logic                 lfsr_done;

   logic [SLOT_IW-1:0]   cur_idx;
   logic [ADDR_BITS-1:0] rd_addr_eff;
   logic [LABEL_W-1:0]   rd_lab_eff;
   logic                 node_is_leaf;
   logic                 walk_end;
   logic [NODE_W-1:0]    adv_node;
   logic [SB_W-1:0]      adv_slot;
   logic [NODE_W-1:0]    leaf_node;
   logic [ADDR_BITS-1:0] st_addr;
   logic [LABEL_W-1:0]   st_lab;
   logic                 fits;
   logic [ADDR_BITS-1:0] dummy;
   logic                 out_free;
   logic [LABEL_W-1:0]   raw_leaf;
   logic [NODE_W-1:0]    clamp_leaf;

   assign cur_idx = SLOT_IW'((int'(node_ff) - 1) * BUCKET_SLOTS + int'(slot_ff));
   assign node_is_leaf = (int'(node_ff) >= LEAVES);
   assign rd_addr_eff = vld_ff[rd_idx_ff] ? slot_rdata[ADDR_BITS-1:0] : '0;
   assign rd_lab_eff = vld_ff[rd_idx_ff] ? slot_rdata[ENTRY_W-1:ADDR_BITS] :
                       (node_is_leaf ? LABEL_W'(int'(node_ff) - LEAVES + 1) : '0);
   assign walk_end = (slot_ff == '0) && (node_ff == NODE_W'(1));
   assign adv_node = (slot_ff == '0) ? (node_ff >> 1) : node_ff;
   assign adv_slot = (slot_ff == '0) ? SB_W'(BUCKET_SLOTS - 1) : slot_ff - 1'b1;
   assign leaf_node = NODE_W'(LEAVES - 1 + int'(leaf_ff));
   assign st_addr = stash_rdata[ADDR_BITS-1:0];
   assign st_lab = stash_rdata[ENTRY_W-1:ADDR_BITS];
   assign fits = (st_lab != '0) && (int'(st_lab) <= LEAVES) &&
                 (((int'(st_lab) + LEAVES - 1) >> sh_ff) == int'(node_ff));
   assign dummy = (ADDR_BITS'(lfsr_value) == '0) ? ADDR_BITS'(1) : ADDR_BITS'(lfsr_value);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign raw_leaf = req_tdata[4:0];
   assign clamp_leaf = (raw_leaf == '0) ? NODE_W'(1) :
                       ((int'(raw_leaf) > LEAVES) ? NODE_W'(LEAVES) : NODE_W'(raw_leaf));
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      leaf_in      = leaf_ff;
      addr_in      = addr_ff;
      nl_in        = nl_ff;
      node_in      = node_ff;
      slot_in      = slot_ff;
      sh_in        = sh_ff;
      status_in    = status_ff;
      fill_in      = fill_ff;
      j_in         = j_ff;
      w_in         = w_ff;
      full_in      = full_ff;
      tcnt_in      = tcnt_ff;
      eidx_in      = eidx_ff;
      dfe_in       = dfe_ff;
      rd_idx_in    = rd_idx_ff;
      vld_in       = vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_last_in  = rsp_last_ff;
      slot_we      = 1'b0;
      slot_re      = 1'b0;
      slot_waddr   = cur_idx;
      slot_wdata   = '0;
      stash_we     = 1'b0;
      stash_re     = 1'b0;
      stash_waddr  = fill_ff[STASH_IW-1:0];
      stash_raddr  = j_ff[STASH_IW-1:0];
      stash_wdata  = '0;
      trace_we     = 1'b0;
      trace_re     = 1'b0;
      trace_waddr  = tcnt_ff[TIDX_W-1:0];
      trace_raddr  = eidx_ff[TIDX_W-1:0];
      trace_wdata  = '0;
      lfsr_ctrl    = '{load: 1'b0, start: 1'b0, seed: csr_wdata};

      if (csr_wen) begin
         unique case (csr_index)
            CSR_DUMMY_EN: dfe_in = csr_wdata[0];
            CSR_SEED:     lfsr_ctrl.load = 1'b1;
            default:      ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_tuser;
               leaf_in   = clamp_leaf;
               addr_in   = ADDR_BITS'(req_tdata[36:5]);
               nl_in     = req_tdata[41:37];
               node_in   = NODE_W'(LEAVES - 1 + int'(clamp_leaf));
               slot_in   = SB_W'(BUCKET_SLOTS - 1);
               status_in = ST_OK;
               tcnt_in   = '0;
               eidx_in   = '0;
               state_in  = (req_tuser == OP_PLACE) ? S_P_RD : S_A_RD;
            end
         end
         S_P_RD: begin
            slot_re   = 1'b1;
            rd_idx_in = cur_idx;
            state_in  = S_P_EV;
         end
         S_P_EV: begin
            if (rd_addr_eff == '0) begin
               slot_we  = 1'b1;
               slot_wdata = {LABEL_W'(leaf_ff), addr_ff};
               vld_in[cur_idx] = 1'b1;
               state_in = S_E_RD;
            end else if (walk_end) begin
               status_in = ST_NO_SLOT;
               state_in  = S_E_RD;
            end else begin
               node_in  = adv_node;
               slot_in  = adv_slot;
               state_in = S_P_RD;
            end
         end
         S_A_RD: begin
            slot_re   = 1'b1;
            rd_idx_in = cur_idx;
            state_in  = S_A_EV;
         end
         S_A_EV: begin
            // clear the slot; leaf slots keep their own label
            slot_we    = 1'b1;
            slot_wdata = {node_is_leaf ? rd_lab_eff : LABEL_W'(0), ADDR_BITS'(0)};
            vld_in[cur_idx] = 1'b1;
            if (rd_addr_eff != '0) begin
               trace_we = 1'b1;
               tcnt_in  = tcnt_ff + 1'b1;
               if (int'(fill_ff) < STASH_DEPTH) begin
                  stash_we    = 1'b1;
                  stash_wdata = {(rd_addr_eff == addr_ff) ? nl_ff : rd_lab_eff, rd_addr_eff};
                  fill_in     = fill_ff + 1'b1;
                  trace_wdata = {1'b0, IN_ADDR_W'(rd_addr_eff)};
               end else begin
                  status_in   = ST_OVERFLOW;
                  trace_wdata = {1'b1, IN_ADDR_W'(rd_addr_eff)};
               end
            end
            if (walk_end) begin
               node_in  = leaf_node;
               slot_in  = SB_W'(BUCKET_SLOTS - 1);
               sh_in    = '0;
               j_in     = '0;
               w_in     = '0;
               full_in  = 1'b0;
               state_in = S_W_RD;
            end else begin
               node_in  = adv_node;
               slot_in  = adv_slot;
               state_in = S_A_RD;
            end
         end
         S_W_RD: begin
            if (j_ff == fill_ff) begin
               fill_in = w_ff;
               if (node_ff == NODE_W'(1)) begin
                  node_in  = leaf_node;
                  slot_in  = SB_W'(BUCKET_SLOTS - 1);
                  state_in = dfe_ff ? S_D_RD : S_E_RD;
               end else begin
                  node_in  = node_ff >> 1;
                  sh_in    = sh_ff + 1'b1;
                  slot_in  = SB_W'(BUCKET_SLOTS - 1);
                  j_in     = '0;
                  w_in     = '0;
                  full_in  = 1'b0;
                  state_in = S_W_RD;
               end
            end else begin
               stash_re = 1'b1;
               state_in = S_W_EV;
            end
         end
         S_W_EV: begin
            // taken entries leave; the rest are compacted down in order
            if (!full_ff && fits) begin
               slot_we    = 1'b1;
               slot_wdata = stash_rdata;
               vld_in[cur_idx] = 1'b1;
               if (slot_ff == '0) begin
                  full_in = 1'b1;
               end else begin
                  slot_in = slot_ff - 1'b1;
               end
            end else begin
               stash_we    = 1'b1;
               stash_waddr = w_ff[STASH_IW-1:0];
               stash_wdata = stash_rdata;
               w_in        = w_ff + 1'b1;
            end
            j_in     = j_ff + 1'b1;
            state_in = S_W_RD;
         end
         S_D_RD: begin
            slot_re   = 1'b1;
            rd_idx_in = cur_idx;
            state_in  = S_D_EV;
         end
         S_D_EV: begin
            if (rd_addr_eff == '0) begin
               lfsr_ctrl.start = 1'b1;
               state_in = S_D_GEN;
            end else begin
               node_in  = adv_node;
               slot_in  = adv_slot;
               state_in = walk_end ? S_E_RD : S_D_RD;
            end
         end
         S_D_GEN: begin
            if (lfsr_done) begin
               slot_we    = 1'b1;
               slot_wdata = {rd_lab_eff, dummy};
               vld_in[cur_idx] = 1'b1;
               node_in  = adv_node;
               slot_in  = adv_slot;
               state_in = walk_end ? S_E_RD : S_D_RD;
            end
         end
         S_E_RD: begin
            if (eidx_ff == tcnt_ff) begin
               state_in = S_E_DONE;
            end else begin
               trace_re = 1'b1;
               state_in = S_E_EV;
            end
         end
         S_E_EV: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_TRACE;
               rsp_addr_in  = trace_rdata[IN_ADDR_W-1:0];
               rsp_cnt_in   = CNT_OUT_W'(fill_ff);
               rsp_st_in    = trace_rdata[IN_ADDR_W] ? ST_OVERFLOW : ST_OK;
               rsp_last_in  = 1'b0;
               eidx_in      = eidx_ff + 1'b1;
               state_in     = S_E_RD;
            end
         end
         S_E_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_DONE;
               rsp_addr_in  = '0;
               rsp_cnt_in   = CNT_OUT_W'(fill_ff);
               rsp_st_in    = status_ff;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         dfe_ff       <= 1'b1;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         tcnt_ff      <= '0;
         eidx_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         dfe_ff       <= dfe_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
         tcnt_ff      <= tcnt_in;
         eidx_ff      <= eidx_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      leaf_ff     <= leaf_in;
      addr_ff     <= addr_in;
      nl_ff       <= nl_in;
      node_ff     <= node_in;
      slot_ff     <= slot_in;
      sh_ff       <= sh_in;
      status_ff   <= status_in;
      j_ff        <= j_in;
      w_ff        <= w_in;
      full_ff     <= full_in;
      rd_idx_ff   <= rd_idx_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_last_ff <= rsp_last_in;
   end

   poram_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_en   (slot_re),
      .rd_addr (cur_idx),
      .rd_data (slot_rdata)
   );

   poram_ram #(.WIDTH(ENTRY_W), .DEPTH(STASH_DEPTH)) u_stash_ram (
      .clock   (clock),
      .wr_en   (stash_we),
      .wr_addr (stash_waddr),
      .wr_data (stash_wdata),
      .rd_en   (stash_re),
      .rd_addr (stash_raddr),
      .rd_data (stash_rdata)
   );

   poram_ram #(.WIDTH(TRACE_W), .DEPTH(TRACES)) u_trace_ram (
      .clock   (clock),
      .wr_en   (trace_we),
      .wr_addr (trace_waddr),
      .wr_data (trace_wdata),
      .rd_en   (trace_re),
      .rd_addr (trace_raddr),
      .rd_data (trace_rdata)
   );

   poram_lfsr u_lfsr (
      .clock (clock),
      .reset (reset),
      .ctrl  (lfsr_ctrl),
      .value (lfsr_value),
      .done  (lfsr_done)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {rsp_st_ff, rsp_cnt_ff, rsp_addr_ff};

   `POA_ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready, state_ff != S_IDLE, "request accepted but sequencer stayed idle")
   `POA_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, int'(fill_ff) <= STASH_DEPTH, "stash fill beyond depth")
   `POA_ASSERT_NOW(a_trace_bound, clock, reset, 1'b1, int'(tcnt_ff) <= TRACES && eidx_ff <= tcnt_ff, "trace buffer count out of range")
   `POA_ASSERT_NOW(a_last_kind, clock, reset, rsp_valid_ff, rsp_last_ff == rsp_kind_ff, "tlast and completion kind disagree")
   `POA_ASSERT_NOW(a_place_no_trace, clock, reset, state_ff != S_IDLE && op_ff == OP_PLACE, tcnt_ff == '0, "place request produced a trace")
endmodule

>>> rtl/poram_ram.sv
module poram_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/poram_lfsr.sv
module poram_lfsr (
   input  logic                           clock,
   input  logic                           reset,
   input  poram_pkg::lfsr_ctrl_type       ctrl,
   output logic [poram_pkg::LFSR_W-1:0]   value,
   output logic                           done
);
   import poram_pkg::*;

   localparam int CNT_W = (LFSR_ROUNDS > 1) ? $clog2(LFSR_ROUNDS) : 1;

   logic [LFSR_W-1:0] lfsr_ff, lfsr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   always_comb begin
      lfsr_in = lfsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.load) begin
         lfsr_in = (ctrl.seed == '0) ? LFSR_W'(1) : ctrl.seed;
      end else if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         lfsr_in = lfsr_chunk(lfsr_ff);
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(LFSR_ROUNDS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= LFSR_W'(1);
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         lfsr_ff <= lfsr_in;
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign value = lfsr_ff;
   assign done  = done_ff;
endmodule

>>> sim/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import poram_pkg::*;

   localparam int LEAVES = 16;
   localparam int SLOTS  = 62;
   localparam int STASH  = 32;

   typedef struct {
      logic        kind;
      logic [31:0] addr;
      logic [5:0]  cnt;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   typedef struct {
      logic [31:0] addr;
      logic [4:0]  lab;
   } blk_type;

   typedef struct {
      logic        op;
      logic [4:0]  leaf;
      logic [31:0] addr;
      logic [4:0]  nl;
      bit          typed;
      logic [1:0]  e_status;
      logic [5:0]  e_cnt;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wen = 1'b0;
   logic        csr_index = 1'b0;
   logic [31:0] csr_wdata = '0;

   path_oram_access dut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [31:0] tree_addr[SLOTS];
   logic [4:0]  tree_lab[SLOTS];
   blk_type     stash_q[$];
   logic [31:0] dummy_gen;
   logic        fill_en;
   rsp_type     pending_rsp[$];
   int          errors = 0;
   int          burst_left = 0;
   logic [31:0] used_addr[$];

   int          hold_left = 0;
   logic        hold_go = 1'b0;
   int          ready_pct = 100;
   logic [7:0]  cyc = '0;

   function automatic logic [31:0] next_dummy();
      logic lsb;
      for (int i = 0; i < 32; i++) begin
         lsb = dummy_gen[0];
         dummy_gen = dummy_gen >> 1;
         if (lsb) dummy_gen ^= LFSR_MASK;
      end
      return (dummy_gen == 0) ? 32'd1 : dummy_gen;
   endfunction

   // Apply one request to the tree model and queue the results it produces.
   function automatic void oram_apply(logic op, logic [4:0] leaf_in, logic [31:0] addr,
                                      logic [4:0] nl);
      int leaf, leaf_node, idx, level, span, left, right, slot, j;
      bit found;
      logic [1:0] status;
      rsp_type trace[$];
      rsp_type r;
      blk_type b;
      leaf = leaf_in;
      status = ST_OK;
      found = 0;
      if (leaf < 1) leaf = 1;
      if (leaf > LEAVES) leaf = LEAVES;
      leaf_node = LEAVES - 1 + leaf;
      if (op == OP_PLACE) begin
         for (int n = leaf_node; n >= 1 && !found; n >>= 1)
            for (int s = 1; s >= 0 && !found; s--) begin
               idx = (n - 1) * 2 + s;
               if (tree_addr[idx] == 0) begin
                  tree_addr[idx] = addr;
                  tree_lab[idx] = 5'(leaf);
                  found = 1;
               end
            end
         if (!found) status = ST_NO_SLOT;
      end else begin
         level = 4;
         for (int n = leaf_node; n >= 1; n >>= 1) begin
            for (int s = 1; s >= 0; s--) begin
               idx = (n - 1) * 2 + s;
               b.addr = tree_addr[idx];
               b.lab = (tree_addr[idx] == addr) ? nl : tree_lab[idx];
               tree_addr[idx] = 0;
               if (level != 4) tree_lab[idx] = 0;
               if (b.addr != 0) begin
                  r = '{KIND_TRACE, b.addr, 6'd0, ST_OK, 1'b0};
                  if (stash_q.size() < STASH) stash_q = {stash_q, b};
                  else begin
                     r.status = ST_OVERFLOW;
                     status = ST_OVERFLOW;
                  end
                  trace = {trace, r};
               end
            end
            level--;
         end
         level = 4;
         for (int n = leaf_node; n >= 1; n >>= 1) begin
            span = 1 << (4 - level);
            left = (n - (1 << level)) * span + 1;
            right = left + span - 1;
            slot = 1;
            j = 0;
            while (j < stash_q.size()) begin
               if (stash_q[j].lab >= left && stash_q[j].lab <= right) begin
                  idx = (n - 1) * 2 + slot;
                  tree_addr[idx] = stash_q[j].addr;
                  tree_lab[idx] = stash_q[j].lab;
                  stash_q.delete(j);
                  if (slot == 0) break;
                  slot--;
               end else begin
                  j++;
               end
            end
            level--;
         end
         if (fill_en)
            for (int n = leaf_node; n >= 1; n >>= 1)
               for (int s = 1; s >= 0; s--) begin
                  idx = (n - 1) * 2 + s;
                  if (tree_addr[idx] == 0) tree_addr[idx] = next_dummy();
               end
      end
      foreach (trace[i]) begin
         trace[i].cnt = 6'(stash_q.size());
         pending_rsp = {pending_rsp, trace[i]};
      end
      r = '{KIND_DONE, 32'd0, 6'(stash_q.size()), status, 1'b1};
      pending_rsp = {pending_rsp, r};
   endfunction

   task automatic report(string what, logic [39:0] got, logic [39:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // receiver: check every transfer and stall on a drifting pattern
   always @(posedge clock) begin
      rsp_type e;
      cyc <= cyc + 1'b1;
      if (cyc == 8'd0) ready_pct <= (($urandom_range(0, 2) == 0) ? 100 : $urandom_range(20, 90));
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_rsp.size() == 0) begin
               report("unexpected result", rsp_tdata, '0);
            end else begin
               e = pending_rsp[0];
               pending_rsp.delete(0);
               if (rsp_tuser !== e.kind) report("kind", 40'(rsp_tuser), 40'(e.kind));
               if (rsp_tdata[31:0] !== e.addr)
                  report("read_address", 40'(rsp_tdata[31:0]), 40'(e.addr));
               if (rsp_tdata[37:32] !== e.cnt)
                  report("stash_count", 40'(rsp_tdata[37:32]), 40'(e.cnt));
               if (rsp_tdata[39:38] !== e.status)
                  report("status", 40'(rsp_tdata[39:38]), 40'(e.status));
               if (rsp_tlast !== e.last) report("last", 40'(rsp_tlast), 40'(e.last));
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(0, 99) < ready_pct);
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_left != 0) hold_left <= hold_left - 1;
      else if (hold_go) hold_left <= 1500;
   end

   task automatic send(logic op, logic [4:0] leaf, logic [31:0] addr, logic [4:0] nl);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {6'd0, nl, addr, leaf};
      do @(posedge clock); while (!req_tready);
      oram_apply(op, leaf, addr, nl);
      if (op == OP_PLACE && addr != 0) used_addr = {used_addr, addr};
      if (used_addr.size() > 40) used_addr.delete(0);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         burst_left = $urandom_range(0, 8);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [31:0] val);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (idx == CSR_DUMMY_EN) begin
         fill_en = val[0];
      end else begin
         dummy_gen = (val == 0) ? 32'd1 : val;
      end
   endtask

   task automatic random_items(int count, int good_pct);
      logic        op;
      logic [4:0]  leaf, nl;
      logic [31:0] addr;
      for (int i = 0; i < count; i++) begin
         op = $urandom_range(0, 99) < 45 ? OP_PLACE : OP_ACCESS;
         if ($urandom_range(0, 99) < good_pct) begin
            leaf = 5'($urandom_range(1, LEAVES));
            nl = 5'($urandom_range(1, LEAVES));
            if (op == OP_ACCESS && used_addr.size() != 0)
               addr = used_addr[$urandom_range(0, used_addr.size() - 1)];
            else
               addr = $urandom();
         end else begin
            leaf = 5'($urandom_range(0, 31));
            nl = 5'($urandom_range(0, 31));
            addr = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom();
         end
         send(op, leaf, addr, nl);
      end
   endtask

   row_type directed[19] = '{
      '{OP_PLACE, 5'd0, 32'hFFFF_FFFF, 5'd0, 1, ST_OK, 6'd0},
      '{OP_PLACE, 5'd31, 32'd1, 5'd0, 1, ST_OK, 6'd0},
      '{OP_PLACE, 5'd16, 32'd0, 5'd0, 1, ST_OK, 6'd0},
      '{OP_PLACE, 5'd1, 32'd2, 5'd0, 0, ST_OK, 6'd0},
      '{OP_PLACE, 5'd1, 32'd3, 5'd0, 0, ST_OK, 6'd0},
      '{OP_PLACE, 5'd1, 32'd4, 5'd0, 0, ST_OK, 6'd0},
      '{OP_PLACE, 5'd1, 32'd5, 5'd0, 0, ST_OK, 6'd0},
      '{OP_PLACE, 5'd1, 32'd6, 5'd0, 0, ST_OK, 6'd0},
      '{OP_PLACE, 5'd1, 32'd7, 5'd0, 0, ST_OK, 6'd0},
      '{OP_PLACE, 5'd1, 32'd8, 5'd0, 0, ST_OK, 6'd0},
      '{OP_PLACE, 5'd1, 32'd9, 5'd0, 0, ST_OK, 6'd0},
      '{OP_PLACE, 5'd1, 32'd10, 5'd0, 0, ST_OK, 6'd0},
      '{OP_PLACE, 5'd1, 32'd11, 5'd0, 1, ST_NO_SLOT, 6'd0},
      '{OP_ACCESS, 5'd1, 32'hFFFF_FFFF, 5'd31, 0, ST_OK, 6'd0},
      '{OP_ACCESS, 5'd16, 32'd1, 5'd0, 0, ST_OK, 6'd0},
      '{OP_ACCESS, 5'd8, 32'd0, 5'd16, 0, ST_OK, 6'd0},
      '{OP_ACCESS, 5'd1, 32'd3, 5'd1, 0, ST_OK, 6'd0},
      '{OP_ACCESS, 5'd0, 32'd5, 5'd16, 0, ST_OK, 6'd0},
      '{OP_ACCESS, 5'd31, 32'd7, 5'd1, 0, ST_OK, 6'd0}
   };

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         tree_addr[i] = '0;
         tree_lab[i] = (i >= 30) ? 5'((i - 30) / 2 + 1) : 5'd0;
      end
      fill_en = 1'b1;
      dummy_gen = 32'd1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_write(CSR_DUMMY_EN, 32'd0);
      foreach (directed[i]) begin
         send(directed[i].op, directed[i].leaf, directed[i].addr, directed[i].nl);
         // typed rows: override the completion with the hand-read values
         if (directed[i].typed) begin
            pending_rsp[$].status = directed[i].e_status;
            pending_rsp[$].cnt = directed[i].e_cnt;
         end
      end
      drain();
      csr_write(CSR_SEED, 32'h1234_5678);
      random_items(180, 85);
      drain();
      csr_write(CSR_DUMMY_EN, 32'd1);
      csr_write(CSR_SEED, 32'd0);
      random_items(100, 80);
      // hold the receiver off while requests keep coming
      hold_go <= 1'b1;
      @(posedge clock);
      hold_go <= 1'b0;
      random_items(30, 80);
      // pause until everything is back
      drain();
      csr_write(CSR_SEED, 32'hFFFF_FFFF);
      random_items(80, 70);
      drain();
      csr_write(CSR_DUMMY_EN, 32'd0);
      random_items(90, 60);
      drain();
      repeat (200) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         if (pending_rsp.size() != 0) $display("%0d results never arrived", pending_rsp.size());
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("DONE: errors detected");
      $finish;
   end
endmodule
